### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the time-of-day arithmetic RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

`endif

### hw/rtl/tod_pkg.sv
// ----------------------------------------------------------------------------
// Time-of-day arithmetic package
// Operation codes, transaction structs and the fixed reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tod_pkg;

   // Operation codes carried in the op field of a request.
   typedef enum logic [2:0] {
      OP_TO_SECONDS   = 3'd0,
      OP_FROM_SECONDS = 3'd1,
      OP_ADD_SECONDS  = 3'd2,
      OP_DURATION     = 3'd3,
      OP_COMPARE      = 3'd4
   } op_type;

   // Clock arithmetic constants.
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned HOURS_PER_DAY = 24;
   localparam int unsigned MINS_PER_HOUR = 60;
   localparam int unsigned SECS_PER_DAY  = 24 * 60 * 60;

   // Widths of the internal seconds values.
   localparam int unsigned SECS_W = 17;
   localparam int unsigned WIDE_W = 34;

   // Day wrap: 86400 = 128 * 675. The quotient by 128 is biased by a
   // multiple of 675 so that it is never negative, then divided by 675
   // through a reciprocal multiply with one correction step.
   localparam int unsigned WRAP_SHIFT       = 7;
   localparam int unsigned WRAP_Y_W         = 28;
   localparam int unsigned WRAP_Q_W         = 19;
   localparam int unsigned WRAP_RECIP_SHIFT = 38;
   localparam logic [9:0]  WRAP_ODD         = 10'd675;
   localparam logic [27:0] WRAP_BIAS        = 28'd67109175;
   localparam logic [28:0] WRAP_RECIP       = 29'd407226528;

   // Reciprocals for splitting seconds into hours and minutes.
   localparam int unsigned HOUR_RECIP_SHIFT = 29;
   localparam logic [17:0] HOUR_RECIP       = 18'd149130;
   localparam int unsigned MIN_RECIP_SHIFT  = 18;
   localparam logic [12:0] MIN_RECIP        = 13'd4369;

   // Request transaction.
   typedef struct packed {
      logic [2:0]         op;
      logic [4:0]         a_hour;
      logic [5:0]         a_minute;
      logic [5:0]         a_second;
      logic [4:0]         b_hour;
      logic [5:0]         b_minute;
      logic [5:0]         b_second;
      logic signed [31:0] offset_seconds;
   } req_type;

   // Response transaction.
   typedef struct packed {
      logic [4:0]  r_hour;
      logic [5:0]  r_minute;
      logic [5:0]  r_second;
      logic [16:0] total_seconds;
      logic        a_valid;
      logic        is_equal;
      logic        is_less;
      logic        is_greater;
   } rsp_type;

   // Side information that travels with an item through the wrap pipeline.
   typedef struct packed {
      logic [2:0]  op;
      logic        a_valid;
      logic        is_equal;
      logic        is_less;
      logic        is_greater;
      logic [16:0] a_secs;
   } tag_type;

endpackage

`default_nettype wire

### hw/rtl/tod_day_wrap.sv
// ----------------------------------------------------------------------------
// Day wrap pipeline
// Reduces a signed 34-bit second count to 0..86399 with a floor modulo,
// in four register stages.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tod_day_wrap
   import tod_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic signed [WIDE_W-1:0] in_x,
   input  wire tag_type                  in_tag,
   output logic                          out_valid,
   output logic [SECS_W-1:0]             out_w,
   output tag_type                       out_tag
);

   localparam int unsigned PROD_W = WRAP_Y_W + 29;

   // Stage 1: split off the low seven bits and bias the quotient.
   logic                      w1_valid_ff;
   logic [WRAP_Y_W-1:0]       w1_ybias_ff, w1_ybias_in;
   logic [WRAP_SHIFT-1:0]     w1_lo_ff;
   tag_type                   w1_tag_ff;

   // Stage 2: reciprocal quotient estimate.
   logic                      w2_valid_ff;
   logic [PROD_W-1:0]         w2_prod;
   logic [WRAP_Q_W-1:0]       w2_qest_ff, w2_qest_in;
   logic [WRAP_Y_W-1:0]       w2_ybias_ff;
   logic [WRAP_SHIFT-1:0]     w2_lo_ff;
   tag_type                   w2_tag_ff;

   // Stage 3: remainder estimate, at most one divisor too large.
   logic                      w3_valid_ff;
   logic [WRAP_Y_W-1:0]       w3_diff;
   logic [10:0]               w3_rem_ff, w3_rem_in;
   logic [WRAP_SHIFT-1:0]     w3_lo_ff;
   tag_type                   w3_tag_ff;

   // Stage 4: corrected remainder joined with the low bits.
   logic                      w4_valid_ff;
   logic [10:0]               w4_rem;
   logic [SECS_W-1:0]         w4_w_ff, w4_w_in;
   tag_type                   w4_tag_ff;

   // The arithmetic shift keeps the floor; the bias is a multiple of 675.
   assign w1_ybias_in = {in_x[WIDE_W-1], in_x[WIDE_W-1:WRAP_SHIFT]} + WRAP_BIAS;

   // The estimate is the true quotient or one below it.
   assign w2_prod    = PROD_W'(w1_ybias_ff) * PROD_W'(WRAP_RECIP);
   assign w2_qest_in = w2_prod[WRAP_RECIP_SHIFT +: WRAP_Q_W];

   assign w3_diff   = w2_ybias_ff - WRAP_Y_W'(w2_qest_ff) * WRAP_Y_W'(WRAP_ODD);
   assign w3_rem_in = w3_diff[10:0];

   // One compare and subtract brings the remainder below 675.
   always_comb begin
      if (w3_rem_ff >= 11'(WRAP_ODD)) begin
         w4_rem = w3_rem_ff - 11'(WRAP_ODD);
      end else begin
         w4_rem = w3_rem_ff;
      end
      w4_w_in = {w4_rem[9:0], w3_lo_ff};
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         w1_valid_ff <= 1'b0;
         w2_valid_ff <= 1'b0;
         w3_valid_ff <= 1'b0;
         w4_valid_ff <= 1'b0;
      end else begin
         w1_valid_ff <= in_valid;
         w2_valid_ff <= w1_valid_ff;
         w3_valid_ff <= w2_valid_ff;
         w4_valid_ff <= w3_valid_ff;
      end
   end

   // Payload registers of the stages.
   always_ff @(posedge clock) begin
      w1_ybias_ff <= w1_ybias_in;
      w1_lo_ff    <= in_x[WRAP_SHIFT-1:0];
      w1_tag_ff   <= in_tag;

      w2_qest_ff  <= w2_qest_in;
      w2_ybias_ff <= w1_ybias_ff;
      w2_lo_ff    <= w1_lo_ff;
      w2_tag_ff   <= w1_tag_ff;

      w3_rem_ff   <= w3_rem_in;
      w3_lo_ff    <= w2_lo_ff;
      w3_tag_ff   <= w2_tag_ff;

      w4_w_ff     <= w4_w_in;
      w4_tag_ff   <= w3_tag_ff;
   end

   assign out_valid = w4_valid_ff;
   assign out_w     = w4_w_ff;
   assign out_tag   = w4_tag_ff;

   `ASSERT_IMPLIES(a_wrap_in_day, clock, reset, out_valid, out_w < SECS_W'(SECS_PER_DAY))

endmodule

`default_nettype wire

### hw/rtl/tod_hms_split.sv
// ----------------------------------------------------------------------------
// Seconds to hour, minute and second
// Splits a count in 0..86399 by reciprocal multiplies, in six register
// stages.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tod_hms_split
   import tod_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [SECS_W-1:0] in_w,
   input  wire tag_type           in_tag,
   output logic                   out_valid,
   output logic [4:0]             out_hour,
   output logic [5:0]             out_minute,
   output logic [5:0]             out_second,
   output logic [SECS_W-1:0]      out_w,
   output tag_type                out_tag
);

   localparam int unsigned HPROD_W = SECS_W + 18;
   localparam int unsigned MPROD_W = 12 + 13;

   // Stage 1: hour estimate.
   logic               h1_valid_ff;
   logic [HPROD_W-1:0] h1_prod;
   logic [4:0]         h1_hour_ff;
   logic [SECS_W-1:0]  h1_w_ff;
   tag_type            h1_tag_ff;

   // Stage 2: seconds within the estimated hour.
   logic               h2_valid_ff;
   logic [SECS_W-1:0]  h2_diff;
   logic [12:0]        h2_ms_ff;
   logic [4:0]         h2_hour_ff;
   logic [SECS_W-1:0]  h2_w_ff;
   tag_type            h2_tag_ff;

   // Stage 3: hour correction.
   logic               h3_valid_ff;
   logic [12:0]        h3_ms_full;
   logic [11:0]        h3_ms_ff, h3_ms_in;
   logic [4:0]         h3_hour_ff, h3_hour_in;
   logic [SECS_W-1:0]  h3_w_ff;
   tag_type            h3_tag_ff;

   // Stage 4: minute estimate.
   logic               h4_valid_ff;
   logic [MPROD_W-1:0] h4_prod;
   logic [5:0]         h4_min_ff;
   logic [11:0]        h4_ms_ff;
   logic [4:0]         h4_hour_ff;
   logic [SECS_W-1:0]  h4_w_ff;
   tag_type            h4_tag_ff;

   // Stage 5: second estimate.
   logic               h5_valid_ff;
   logic [11:0]        h5_diff;
   logic [6:0]         h5_sec_ff;
   logic [5:0]         h5_min_ff;
   logic [4:0]         h5_hour_ff;
   logic [SECS_W-1:0]  h5_w_ff;
   tag_type            h5_tag_ff;

   // Stage 6: minute correction.
   logic               h6_valid_ff;
   logic [6:0]         h6_sec_full;
   logic [5:0]         h6_sec_ff, h6_sec_in;
   logic [5:0]         h6_min_ff, h6_min_in;
   logic [4:0]         h6_hour_ff;
   logic [SECS_W-1:0]  h6_w_ff;
   tag_type            h6_tag_ff;

   // The hour and minute estimates are exact or one below.
   assign h1_prod = HPROD_W'(in_w) * HPROD_W'(HOUR_RECIP);
   assign h2_diff = h1_w_ff - SECS_W'(h1_hour_ff) * SECS_W'(SECS_PER_HOUR);

   always_comb begin
      if (h2_ms_ff >= 13'(SECS_PER_HOUR)) begin
         h3_hour_in = h2_hour_ff + 5'd1;
         h3_ms_full = h2_ms_ff - 13'(SECS_PER_HOUR);
      end else begin
         h3_hour_in = h2_hour_ff;
         h3_ms_full = h2_ms_ff;
      end
      h3_ms_in = h3_ms_full[11:0];
   end

   assign h4_prod = MPROD_W'(h3_ms_ff) * MPROD_W'(MIN_RECIP);
   assign h5_diff = h4_ms_ff - 12'(h4_min_ff) * 12'(SECS_PER_MIN);

   always_comb begin
      if (h5_sec_ff >= 7'(SECS_PER_MIN)) begin
         h6_min_in   = h5_min_ff + 6'd1;
         h6_sec_full = h5_sec_ff - 7'(SECS_PER_MIN);
      end else begin
         h6_min_in   = h5_min_ff;
         h6_sec_full = h5_sec_ff;
      end
      h6_sec_in = h6_sec_full[5:0];
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
         h2_valid_ff <= 1'b0;
         h3_valid_ff <= 1'b0;
         h4_valid_ff <= 1'b0;
         h5_valid_ff <= 1'b0;
         h6_valid_ff <= 1'b0;
      end else begin
         h1_valid_ff <= in_valid;
         h2_valid_ff <= h1_valid_ff;
         h3_valid_ff <= h2_valid_ff;
         h4_valid_ff <= h3_valid_ff;
         h5_valid_ff <= h4_valid_ff;
         h6_valid_ff <= h5_valid_ff;
      end
   end

   // Payload registers of the stages.
   always_ff @(posedge clock) begin
      h1_hour_ff <= h1_prod[HOUR_RECIP_SHIFT +: 5];
      h1_w_ff    <= in_w;
      h1_tag_ff  <= in_tag;

      h2_ms_ff   <= h2_diff[12:0];
      h2_hour_ff <= h1_hour_ff;
      h2_w_ff    <= h1_w_ff;
      h2_tag_ff  <= h1_tag_ff;

      h3_ms_ff   <= h3_ms_in;
      h3_hour_ff <= h3_hour_in;
      h3_w_ff    <= h2_w_ff;
      h3_tag_ff  <= h2_tag_ff;

      h4_min_ff  <= h4_prod[MIN_RECIP_SHIFT +: 6];
      h4_ms_ff   <= h3_ms_ff;
      h4_hour_ff <= h3_hour_ff;
      h4_w_ff    <= h3_w_ff;
      h4_tag_ff  <= h3_tag_ff;

      h5_sec_ff  <= h5_diff[6:0];
      h5_min_ff  <= h4_min_ff;
      h5_hour_ff <= h4_hour_ff;
      h5_w_ff    <= h4_w_ff;
      h5_tag_ff  <= h4_tag_ff;

      h6_sec_ff  <= h6_sec_in;
      h6_min_ff  <= h6_min_in;
      h6_hour_ff <= h5_hour_ff;
      h6_w_ff    <= h5_w_ff;
      h6_tag_ff  <= h5_tag_ff;
   end

   assign out_valid  = h6_valid_ff;
   assign out_hour   = h6_hour_ff;
   assign out_minute = h6_min_ff;
   assign out_second = h6_sec_ff;
   assign out_w      = h6_w_ff;
   assign out_tag    = h6_tag_ff;

   `ASSERT_IMPLIES(a_split_ranges, clock, reset, out_valid, (out_hour < 5'(HOURS_PER_DAY)) && (out_minute < 6'(MINS_PER_HOUR)) && (out_second < 6'(SECS_PER_MIN)))
   `ASSERT_IMPLIES(a_split_recombines, clock, reset, out_valid, SECS_W'(out_hour) * SECS_W'(SECS_PER_HOUR) + SECS_W'(out_minute) * SECS_W'(SECS_PER_MIN) + SECS_W'(out_second) == out_w)

endmodule

`default_nettype wire

### hw/rtl/time_of_day_arithmetic_top.sv
// ----------------------------------------------------------------------------
// Time-of-day arithmetic unit
// Converts between hour:minute:second and seconds since midnight, adds
// signed offsets, measures wrapped durations and compares two times.
// ----------------------------------------------------------------------------
// The unit takes one request in every clock cycle: busy is never raised, so
// a request is accepted whenever start is high. Each request gives exactly
// one response, shown on rsp_data for one cycle with rsp_strobe high, in
// request order. The strobe rises once the request has passed all the
// register stages. The response cannot be held off, so the receiver must
// take it in that cycle. The pipeline has 13 register stages: two stages
// of operand preparation, four stages of floor modulo 86400 (reciprocal
// multiply by 1/675 and one correction), six stages splitting the count
// into hours, minutes and seconds (two reciprocal multiplies, each with
// its correction), and the output register. Every operation takes the
// same path and the same time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module time_of_day_arithmetic_top
   import tod_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic                     accept;

   // Stage 1: seconds of both times, validity of time A.
   logic                     s1_valid_ff;
   logic [2:0]               s1_op_ff;
   logic                     s1_a_valid_ff, s1_a_valid_in;
   logic [SECS_W-1:0]        s1_ta_ff, s1_ta_in;
   logic [SECS_W-1:0]        s1_tb_ff, s1_tb_in;
   logic signed [31:0]       s1_offs_ff;

   // Stage 2: operand for the day wrap and the compare flags.
   logic signed [WIDE_W-1:0] s2_offs_ext, s2_ta_ext, s2_tb_ext;
   logic                     s2_valid_ff;
   logic signed [WIDE_W-1:0] s2_x_ff, s2_x_in;
   tag_type                  s2_tag_ff, s2_tag_in;

   // Wrap and split pipelines.
   logic                     wr_valid;
   logic [SECS_W-1:0]        wr_w;
   tag_type                  wr_tag;
   logic                     sp_valid;
   logic [4:0]               sp_hour;
   logic [5:0]               sp_minute;
   logic [5:0]               sp_second;
   logic [SECS_W-1:0]        sp_w;
   tag_type                  sp_tag;

   // Output register.
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Every cycle can take a new transaction.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Seconds since midnight of both times, fields used as given.
   always_comb begin
      s1_ta_in = SECS_W'(req_data.a_hour) * SECS_W'(SECS_PER_HOUR)
               + SECS_W'(req_data.a_minute) * SECS_W'(SECS_PER_MIN)
               + SECS_W'(req_data.a_second);
      s1_tb_in = SECS_W'(req_data.b_hour) * SECS_W'(SECS_PER_HOUR)
               + SECS_W'(req_data.b_minute) * SECS_W'(SECS_PER_MIN)
               + SECS_W'(req_data.b_second);
      s1_a_valid_in = (req_data.a_hour < 5'(HOURS_PER_DAY))
                   && (req_data.a_minute < 6'(MINS_PER_HOUR))
                   && (req_data.a_second < 6'(SECS_PER_MIN));
   end

   // Select the signed count that gets wrapped into one day.
   always_comb begin
      s2_offs_ext = $signed({{(WIDE_W-32){s1_offs_ff[31]}}, s1_offs_ff});
      s2_ta_ext   = $signed({{(WIDE_W-SECS_W){1'b0}}, s1_ta_ff});
      s2_tb_ext   = $signed({{(WIDE_W-SECS_W){1'b0}}, s1_tb_ff});
      case (s1_op_ff)
         OP_FROM_SECONDS: begin
            s2_x_in = s2_offs_ext;
         end
         OP_ADD_SECONDS: begin
            s2_x_in = s2_ta_ext + s2_offs_ext;
         end
         OP_DURATION: begin
            s2_x_in = s2_tb_ext - s2_ta_ext;
         end
         default: begin
            s2_x_in = '0;
         end
      endcase
      s2_tag_in.op         = s1_op_ff;
      s2_tag_in.a_valid    = s1_a_valid_ff;
      s2_tag_in.is_equal   = (s1_ta_ff == s1_tb_ff);
      s2_tag_in.is_less    = (s1_ta_ff < s1_tb_ff);
      s2_tag_in.is_greater = (s1_ta_ff > s1_tb_ff);
      s2_tag_in.a_secs     = s1_ta_ff;
   end

   // Valid bits of the front stages and the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= sp_valid;
      end
   end

   // Payload registers of the front stages and the output.
   always_ff @(posedge clock) begin
      s1_op_ff      <= req_data.op;
      s1_a_valid_ff <= s1_a_valid_in;
      s1_ta_ff      <= s1_ta_in;
      s1_tb_ff      <= s1_tb_in;
      s1_offs_ff    <= req_data.offset_seconds;
      s2_x_ff       <= s2_x_in;
      s2_tag_ff     <= s2_tag_in;
      rsp_data_ff   <= rsp_data_in;
   end

   tod_day_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_x      (s2_x_ff),
      .in_tag    (s2_tag_ff),
      .out_valid (wr_valid),
      .out_w     (wr_w),
      .out_tag   (wr_tag)
   );

   tod_hms_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (wr_valid),
      .in_w       (wr_w),
      .in_tag     (wr_tag),
      .out_valid  (sp_valid),
      .out_hour   (sp_hour),
      .out_minute (sp_minute),
      .out_second (sp_second),
      .out_w      (sp_w),
      .out_tag    (sp_tag)
   );

   // Build the response: a_valid is always set, else only the fields of the chosen operation.
   always_comb begin
      rsp_data_in         = '0;
      rsp_data_in.a_valid = sp_tag.a_valid;
      case (sp_tag.op)
         OP_TO_SECONDS: begin
            rsp_data_in.total_seconds = sp_tag.a_secs;
         end
         OP_FROM_SECONDS, OP_ADD_SECONDS: begin
            rsp_data_in.r_hour        = sp_hour;
            rsp_data_in.r_minute      = sp_minute;
            rsp_data_in.r_second      = sp_second;
            rsp_data_in.total_seconds = sp_w;
         end
         OP_DURATION: begin
            rsp_data_in.total_seconds = sp_w;
         end
         OP_COMPARE: begin
            rsp_data_in.is_equal   = sp_tag.is_equal;
            rsp_data_in.is_less    = sp_tag.is_less;
            rsp_data_in.is_greater = sp_tag.is_greater;
         end
         default: begin
            rsp_data_in.total_seconds = '0;
         end
      endcase
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   `ASSERT_NEXT(a_compare_onehot, clock, reset, sp_valid && (sp_tag.op == OP_COMPARE), $onehot({rsp_data.is_equal, rsp_data.is_less, rsp_data.is_greater}))
   `ASSERT_IMPLIES(a_flags_exclusive, clock, reset, rsp_strobe, $onehot0({rsp_data.is_equal, rsp_data.is_less, rsp_data.is_greater}))

endmodule

`default_nettype wire
